// ===== src/ipt_pkg.sv =====
// ipt_pkg: shared codes and types for the interval pressure tracker
// holds the mode codes, sequencer states and the per-position update flags
// no dependencies
package ipt_pkg;

  // interval mode codes
  localparam logic MODE_ADD    = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  // sequencer states, one-hot
  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_WALK   = 6'b000100,
    S_WB     = 6'b001000,
    S_SCAN   = 6'b010000,
    S_SDRAIN = 6'b100000
  } ipt_state_t;

  // side effects of one position update
  typedef struct packed {
    logic clip;   // count saturated at zero or at the top
    logic stale;  // cached maximum can no longer be trusted
  } upd_flags_t;

endpackage

// ===== src/interval_pressure_tracker.sv =====
// interval_pressure_tracker: top level, sequencer around the pressure store
// depends on ipt_pkg, ipt_ram, ipt_update
//
//   channel | ports                                         | handshake
//   --------+-----------------------------------------------+---------------------------
//   input   | in_mode in_range_start in_range_end in_weight | taken when start & !busy
//   result  | out_max_pressure out_clipped                  | out_valid, one-cycle strobe
//
// an item walks its interval one position per cycle (read, modify, write back
// through the single ram port pair), then the S_WB drain state
// a stale maximum adds a rescan of the store, S_SCAN over every entry then S_SDRAIN
// an empty interval gives its result the cycle after it is taken
// after reset a clearing pass writes zero to all POSITIONS entries, busy stays high
// the receiver cannot stall; the next word is taken while a result is on the ports
module interval_pressure_tracker #(
  parameter int POSITIONS     = 1024,
  parameter int PRESSURE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_mode,
  input  logic [9:0]  in_range_start,
  input  logic [9:0]  in_range_end,
  input  logic [3:0]  in_weight,
  output logic        out_valid,
  output logic [15:0] out_max_pressure,
  output logic        out_clipped
);
  import ipt_pkg::*;

  localparam int AW   = $clog2(POSITIONS);
  localparam int CW   = (AW + 1 > 11) ? AW + 1 : 11;
  localparam int MAXW = (PRESSURE_BITS > 16) ? PRESSURE_BITS : 16;
  localparam logic [CW-1:0] POS_LIMIT = CW'(POSITIONS);
  localparam logic [CW-1:0] POS_LAST  = CW'(POSITIONS - 1);
  localparam logic [AW-1:0] SCAN_LAST = AW'(POSITIONS - 1);

  ipt_state_t               state_r, state_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic                     out_clip_r, out_clip_nxt;
  logic                     stale_r, stale_nxt;
  logic                     clip_r, clip_nxt;
  logic [PRESSURE_BITS-1:0] cmax_r, cmax_nxt;
  logic                     wb_vld_r, wb_vld_nxt;
  logic                     sv_vld_r, sv_vld_nxt;
  logic [AW-1:0]            scan_r, scan_nxt;
  logic [CW-1:0]            pos_r, pos_nxt;
  logic [CW-1:0]            last_r, last_nxt;
  logic [AW-1:0]            wb_addr_r, wb_addr_nxt;
  logic [PRESSURE_BITS-1:0] best_r, best_nxt;
  logic                     mode_r, mode_nxt;
  logic [3:0]               weight_r, weight_nxt;

  logic                     accept;
  logic [CW-1:0]            first_ext, last_ext, last_eff;
  logic                     empty;
  logic                     we;
  logic [AW-1:0]            waddr, raddr;
  logic [PRESSURE_BITS-1:0] wdata, rd_data, upd_cnt;
  upd_flags_t               upd_flags;
  logic [MAXW-1:0]          cmax_ext;

  // pressure store
  ipt_ram #(
    .WIDTH (PRESSURE_BITS),
    .DEPTH (POSITIONS)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rd_data)
  );

  // per-position saturating update
  ipt_update #(
    .PRESSURE_BITS (PRESSURE_BITS)
  ) u_update (
    .mode       (mode_r),
    .weight     (weight_r),
    .old_cnt    (rd_data),
    .cached_max (cmax_r),
    .new_cnt    (upd_cnt),
    .flags      (upd_flags)
  );

  // interval decode, positions past the store are dropped
  assign accept    = start && !busy;
  assign first_ext = CW'(in_range_start);
  assign last_ext  = CW'(in_range_end);
  assign last_eff  = (last_ext >= POS_LIMIT) ? POS_LAST : last_ext;
  assign empty     = (last_ext < first_ext) || (first_ext >= POS_LIMIT);

  // memory port steering
  always_comb begin
    we    = 1'b0;
    waddr = wb_addr_r;
    wdata = upd_cnt;
    if (state_r == S_CLEAR) begin
      we    = 1'b1;
      waddr = scan_r;
      wdata = '0;
    end else if (wb_vld_r) begin
      we = 1'b1;
    end
    raddr = (state_r == S_WALK) ? pos_r[AW-1:0] : scan_r;
  end

  // sequencer and datapath next state
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    out_clip_nxt  = out_clip_r;
    cmax_nxt      = cmax_r;
    pos_nxt       = pos_r;
    last_nxt      = last_r;
    scan_nxt      = scan_r;
    mode_nxt      = mode_r;
    weight_nxt    = weight_r;
    wb_vld_nxt    = 1'b0;
    sv_vld_nxt    = 1'b0;
    wb_addr_nxt   = wb_addr_r;

    // writeback side effects
    stale_nxt = stale_r | (wb_vld_r & upd_flags.stale);
    clip_nxt  = clip_r | (wb_vld_r & upd_flags.clip);

    // running maximum during the rescan
    best_nxt = (sv_vld_r && (rd_data > best_r)) ? rd_data : best_r;

    unique case (state_r)
      S_CLEAR: begin
        scan_nxt = scan_r + 1'b1;
        if (scan_r == SCAN_LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          mode_nxt   = in_mode;
          weight_nxt = in_weight;
          pos_nxt    = first_ext;
          last_nxt   = last_eff;
          stale_nxt  = 1'b0;
          clip_nxt   = 1'b0;
          if (empty) begin
            out_valid_nxt = 1'b1;
            out_clip_nxt  = 1'b0;
          end else begin
            state_nxt = S_WALK;
          end
        end
      end
      S_WALK: begin
        wb_vld_nxt  = 1'b1;
        wb_addr_nxt = pos_r[AW-1:0];
        pos_nxt     = pos_r + 1'b1;
        if (pos_r == last_r) begin
          state_nxt = S_WB;
        end
      end
      S_WB: begin
        if (stale_nxt) begin
          state_nxt = S_SCAN;
          scan_nxt  = '0;
          best_nxt  = '0;
        end else begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          out_clip_nxt  = clip_nxt;
        end
      end
      S_SCAN: begin
        sv_vld_nxt = 1'b1;
        scan_nxt   = scan_r + 1'b1;
        if (scan_r == SCAN_LAST) begin
          state_nxt = S_SDRAIN;
        end
      end
      S_SDRAIN: begin
        cmax_nxt      = best_nxt;
        stale_nxt     = 1'b0;
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        out_clip_nxt  = clip_r;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
      stale_r     <= 1'b0;
      cmax_r      <= '0;
      wb_vld_r    <= 1'b0;
      sv_vld_r    <= 1'b0;
      scan_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      stale_r     <= stale_nxt;
      cmax_r      <= cmax_nxt;
      wb_vld_r    <= wb_vld_nxt;
      sv_vld_r    <= sv_vld_nxt;
      scan_r      <= scan_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    out_clip_r <= out_clip_nxt;
    clip_r     <= clip_nxt;
    pos_r      <= pos_nxt;
    last_r     <= last_nxt;
    wb_addr_r  <= wb_addr_nxt;
    best_r     <= best_nxt;
    mode_r     <= mode_nxt;
    weight_r   <= weight_nxt;
  end

  // outputs
  assign cmax_ext         = MAXW'(cmax_r);
  assign busy             = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_clipped      = out_clip_r;
  assign out_max_pressure = cmax_ext[15:0];

  // a result only appears once the sequencer is back to idle
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // every taken word leads to work or to an immediate result
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted word dropped");

  // writebacks only follow reads issued by the interval walk
  a_wb_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    wb_vld_r |-> (state_r == S_WALK || state_r == S_WB))
    else $error("writeback outside interval walk");

  // a finished rescan leaves the maximum fresh
  a_rescan_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SDRAIN) |=> (!stale_r && out_valid))
    else $error("rescan did not clear stale flag");

endmodule

// ===== src/ipt_ram.sv =====
// ipt_ram: generic single-clock ram, one write port and one registered read port
// no dependencies
module ipt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== src/ipt_update.sv =====
// ipt_update: saturating add or remove of one weight on one stored count
// also decides whether the update makes the cached maximum stale
// depends on ipt_pkg
module ipt_update #(
  parameter int PRESSURE_BITS = 16
) (
  input  logic                     mode,
  input  logic [3:0]               weight,
  input  logic [PRESSURE_BITS-1:0] old_cnt,
  input  logic [PRESSURE_BITS-1:0] cached_max,
  output logic [PRESSURE_BITS-1:0] new_cnt,
  output ipt_pkg::upd_flags_t      flags
);
  import ipt_pkg::*;

  logic [PRESSURE_BITS:0]   sum;
  logic [PRESSURE_BITS-1:0] wext;

  assign wext = PRESSURE_BITS'(weight);
  assign sum  = {1'b0, old_cnt} + {1'b0, wext};

  // saturating update
  always_comb begin
    unique case (mode)
      MODE_ADD: begin
        flags.stale = 1'b1;
        if (sum[PRESSURE_BITS]) begin
          new_cnt    = '1;
          flags.clip = 1'b1;
        end else begin
          new_cnt    = sum[PRESSURE_BITS-1:0];
          flags.clip = 1'b0;
        end
      end
      MODE_REMOVE: begin
        flags.stale = (old_cnt == cached_max);
        if (old_cnt < wext) begin
          new_cnt    = '0;
          flags.clip = 1'b1;
        end else begin
          new_cnt    = old_cnt - wext;
          flags.clip = 1'b0;
        end
      end
      default: begin
        new_cnt = old_cnt;
        flags   = '0;
      end
    endcase
  end

endmodule
